/* design/tss_pkg.sv */
// shared constants and types for the triangle scanline span core
// no dependencies; every other design file imports this package
`default_nettype none

package tss_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned NUM_LANES      = 2;

  // lane 0 follows the long edge, lane 1 the active short edge
  localparam int unsigned LANE_LONG  = 0;
  localparam int unsigned LANE_SHORT = 1;

  typedef struct packed {
    logic span_valid;
    logic last;
  } tss_flags_t;

endpackage : tss_pkg

`default_nettype wire

/* design/tss_in_if.sv */
// input channel: three vertices and a row offset with valid/ready
// depends on tss_pkg for the default coordinate width
`default_nettype none

interface tss_in_if
  import tss_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] first_x;
  logic [W-1:0] first_y;
  logic [W-1:0] second_x;
  logic [W-1:0] second_y;
  logic [W-1:0] third_x;
  logic [W-1:0] third_y;
  logic [W-1:0] row_offset;

  modport source (
    output valid, first_x, first_y, second_x, second_y, third_x, third_y, row_offset,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_y, second_x, second_y, third_x, third_y, row_offset,
    output ready
  );
endinterface : tss_in_if

`default_nettype wire

/* design/tss_out_if.sv */
// result channel: one span word per row query with valid/ready
// depends on tss_pkg for the default coordinate width
`default_nettype none

interface tss_out_if
  import tss_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic         span_valid;
  logic [W-1:0] span_y;
  logic [W-1:0] span_left;
  logic [W-1:0] span_right;
  logic         span_last;

  modport source (
    output valid, span_valid, span_y, span_left, span_right, span_last,
    input  ready
  );

  modport sink (
    input  valid, span_valid, span_y, span_left, span_right, span_last,
    output ready
  );
endinterface : tss_out_if

`default_nettype wire

/* design/tss_setup.sv */
// two stages: sort vertices by y, then edge setup (deltas, row index, divisors)
// depends on tss_pkg
`default_nettype none

module tss_setup
  import tss_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [W-1:0]                    x0,
  input  logic [W-1:0]                    y0,
  input  logic [W-1:0]                    x1,
  input  logic [W-1:0]                    y1,
  input  logic [W-1:0]                    x2,
  input  logic [W-1:0]                    y2,
  input  logic [W-1:0]                    off,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tss_flags_t                      out_flags,
  output logic [W-1:0]                    out_y,
  output logic [NUM_LANES-1:0][W-1:0]     out_base,
  output logic [NUM_LANES-1:0]            out_neg,
  output logic [NUM_LANES-1:0][W-1:0]     out_mag,
  output logic [NUM_LANES-1:0][W-1:0]     out_k,
  output logic [NUM_LANES-1:0][W-1:0]     out_d
);

  // ---------------- stage a: sort ----------------
  logic         sa_v_r;
  logic [W-1:0] sa_x_r [3];
  logic [W-1:0] sa_y_r [3];
  logic [W-1:0] sa_off_r;
  logic         sa_flat_r;
  logic [W-1:0] sa_lo_r;
  logic [W-1:0] sa_hi_r;
  logic         sa_rdy;
  logic         sb_rdy;

  logic [W-1:0] sx_c [3];
  logic [W-1:0] sy_c [3];
  logic [W-1:0] lo_c;
  logic [W-1:0] hi_c;
  logic [W-1:0] tx_c;
  logic [W-1:0] ty_c;

  always_comb begin
    sx_c[0] = x0; sy_c[0] = y0;
    sx_c[1] = x1; sy_c[1] = y1;
    sx_c[2] = x2; sy_c[2] = y2;
    tx_c = '0;
    ty_c = '0;
    // same three compare-swaps in the same order, ties keep their place
    if (sy_c[0] > sy_c[1]) begin
      tx_c = sx_c[0]; ty_c = sy_c[0];
      sx_c[0] = sx_c[1]; sy_c[0] = sy_c[1];
      sx_c[1] = tx_c; sy_c[1] = ty_c;
    end
    if (sy_c[0] > sy_c[2]) begin
      tx_c = sx_c[0]; ty_c = sy_c[0];
      sx_c[0] = sx_c[2]; sy_c[0] = sy_c[2];
      sx_c[2] = tx_c; sy_c[2] = ty_c;
    end
    if (sy_c[1] > sy_c[2]) begin
      tx_c = sx_c[1]; ty_c = sy_c[1];
      sx_c[1] = sx_c[2]; sy_c[1] = sy_c[2];
      sx_c[2] = tx_c; sy_c[2] = ty_c;
    end
    lo_c = x0;
    hi_c = x0;
    if (x1 < lo_c) lo_c = x1;
    if (x1 > hi_c) hi_c = x1;
    if (x2 < lo_c) lo_c = x2;
    if (x2 > hi_c) hi_c = x2;
  end

  assign sa_rdy   = !sa_v_r || sb_rdy;
  assign in_ready = sa_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (sa_rdy) begin
      sa_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sa_rdy) begin
      sa_x_r    <= sx_c;
      sa_y_r    <= sy_c;
      sa_off_r  <= off;
      sa_flat_r <= (y0 == y1) && (y0 == y2);
      sa_lo_r   <= lo_c;
      sa_hi_r   <= hi_c;
    end
  end

  // ---------------- stage b: edge setup ----------------
  logic                        sb_v_r;
  tss_flags_t                  sb_flags_r;
  logic [W-1:0]                sb_y_r;
  logic [NUM_LANES-1:0][W-1:0] sb_base_r;
  logic [NUM_LANES-1:0]        sb_neg_r;
  logic [NUM_LANES-1:0][W-1:0] sb_mag_r;
  logic [NUM_LANES-1:0][W-1:0] sb_k_r;
  logic [NUM_LANES-1:0][W-1:0] sb_d_r;

  logic [W-1:0]                h_c;
  logic [W-1:0]                h1_c;
  logic [W-1:0]                h2_c;
  logic                        in_rng_c;
  logic                        second_c;
  logic [W:0]                  dxa_c;
  logic [W:0]                  dxb_c;
  logic [W:0]                  abs_a_c;
  logic [W:0]                  abs_b_c;
  tss_flags_t                  flags_nxt;
  logic [W-1:0]                y_nxt;
  logic [NUM_LANES-1:0][W-1:0] base_nxt;
  logic [NUM_LANES-1:0]        neg_nxt;
  logic [NUM_LANES-1:0][W-1:0] mag_nxt;
  logic [NUM_LANES-1:0][W-1:0] k_nxt;
  logic [NUM_LANES-1:0][W-1:0] d_nxt;

  always_comb begin
    h_c      = sa_y_r[2] - sa_y_r[0];
    h1_c     = sa_y_r[1] - sa_y_r[0];
    h2_c     = sa_y_r[2] - sa_y_r[1];
    in_rng_c = sa_flat_r ? (sa_off_r == '0) : (sa_off_r < h_c);
    second_c = (sa_off_r > h1_c) || (h1_c == '0);
    dxa_c    = {1'b0, sa_x_r[2]} - {1'b0, sa_x_r[0]};
    dxb_c    = second_c ? ({1'b0, sa_x_r[2]} - {1'b0, sa_x_r[1]})
                        : ({1'b0, sa_x_r[1]} - {1'b0, sa_x_r[0]});
    abs_a_c  = dxa_c[W] ? (~dxa_c + 1'b1) : dxa_c;
    abs_b_c  = dxb_c[W] ? (~dxb_c + 1'b1) : dxb_c;

    flags_nxt.span_valid = in_rng_c;
    flags_nxt.last       = in_rng_c && (sa_flat_r || (sa_off_r == (h_c - 1'b1)));
    y_nxt                = sa_y_r[0] + sa_off_r;

    if (sa_flat_r || !in_rng_c) begin
      // no interpolation: quotients come out zero
      base_nxt[LANE_LONG]  = sa_lo_r;
      base_nxt[LANE_SHORT] = sa_hi_r;
      neg_nxt              = '0;
      mag_nxt              = '0;
      k_nxt                = '0;
      d_nxt[LANE_LONG]     = W'(1);
      d_nxt[LANE_SHORT]    = W'(1);
    end else begin
      base_nxt[LANE_LONG]  = sa_x_r[0];
      base_nxt[LANE_SHORT] = second_c ? sa_x_r[1] : sa_x_r[0];
      neg_nxt[LANE_LONG]   = dxa_c[W];
      neg_nxt[LANE_SHORT]  = dxb_c[W];
      mag_nxt[LANE_LONG]   = abs_a_c[W-1:0];
      mag_nxt[LANE_SHORT]  = abs_b_c[W-1:0];
      k_nxt[LANE_LONG]     = sa_off_r;
      k_nxt[LANE_SHORT]    = second_c ? (sa_off_r - h1_c) : sa_off_r;
      d_nxt[LANE_LONG]     = h_c;
      d_nxt[LANE_SHORT]    = second_c ? h2_c : h1_c;
    end
  end

  assign sb_rdy = !sb_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (sb_rdy) begin
      sb_v_r <= sa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sb_rdy) begin
      sb_flags_r <= flags_nxt;
      sb_y_r     <= y_nxt;
      sb_base_r  <= base_nxt;
      sb_neg_r   <= neg_nxt;
      sb_mag_r   <= mag_nxt;
      sb_k_r     <= k_nxt;
      sb_d_r     <= d_nxt;
    end
  end

  assign out_valid = sb_v_r;
  assign out_flags = sb_flags_r;
  assign out_y     = sb_y_r;
  assign out_base  = sb_base_r;
  assign out_neg   = sb_neg_r;
  assign out_mag   = sb_mag_r;
  assign out_k     = sb_k_r;
  assign out_d     = sb_d_r;

endmodule : tss_setup

`default_nettype wire

/* design/tss_mul.sv */
// one stage: |delta| * row index for both edges, registered
// depends on tss_pkg
`default_nettype none

module tss_mul
  import tss_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tss_flags_t                    in_flags,
  input  logic [W-1:0]                  in_y,
  input  logic [NUM_LANES-1:0][W-1:0]   in_base,
  input  logic [NUM_LANES-1:0]          in_neg,
  input  logic [NUM_LANES-1:0][W-1:0]   in_mag,
  input  logic [NUM_LANES-1:0][W-1:0]   in_k,
  input  logic [NUM_LANES-1:0][W-1:0]   in_d,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tss_flags_t                    out_flags,
  output logic [W-1:0]                  out_y,
  output logic [NUM_LANES-1:0][W-1:0]   out_base,
  output logic [NUM_LANES-1:0]          out_neg,
  output logic [NUM_LANES-1:0][W-1:0]   out_d,
  output logic [NUM_LANES-1:0][2*W-1:0] out_m
);

  logic                          v_r;
  tss_flags_t                    flags_r;
  logic [W-1:0]                  y_r;
  logic [NUM_LANES-1:0][W-1:0]   base_r;
  logic [NUM_LANES-1:0]          neg_r;
  logic [NUM_LANES-1:0][W-1:0]   d_r;
  logic [NUM_LANES-1:0][2*W-1:0] m_r;
  logic [NUM_LANES-1:0][2*W-1:0] m_nxt;
  logic                          rdy;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      m_nxt[l] = {{W{1'b0}}, in_mag[l]} * {{W{1'b0}}, in_k[l]};
    end
  end

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      flags_r <= in_flags;
      y_r     <= in_y;
      base_r  <= in_base;
      neg_r   <= in_neg;
      d_r     <= in_d;
      m_r     <= m_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_flags = flags_r;
  assign out_y     = y_r;
  assign out_base  = base_r;
  assign out_neg   = neg_r;
  assign out_d     = d_r;
  assign out_m     = m_r;

endmodule : tss_mul

`default_nettype wire

/* design/tss_div.sv */
// pipelined restoring divider, one quotient bit per stage, both edges side by side
// depends on tss_pkg
`default_nettype none

module tss_div
  import tss_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tss_flags_t                    in_flags,
  input  logic [W-1:0]                  in_y,
  input  logic [NUM_LANES-1:0][W-1:0]   in_base,
  input  logic [NUM_LANES-1:0]          in_neg,
  input  logic [NUM_LANES-1:0][W-1:0]   in_d,
  input  logic [NUM_LANES-1:0][2*W-1:0] in_m,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tss_flags_t                    out_flags,
  output logic [W-1:0]                  out_y,
  output logic [NUM_LANES-1:0][W-1:0]   out_base,
  output logic [NUM_LANES-1:0]          out_neg,
  output logic [NUM_LANES-1:0][W-1:0]   out_d,
  output logic [NUM_LANES-1:0][W-1:0]   out_rem,
  output logic [NUM_LANES-1:0][W-1:0]   out_quo
);

  logic                        v_r    [W];
  tss_flags_t                  flags_r[W];
  logic [W-1:0]                y_r    [W];
  logic [NUM_LANES-1:0][W-1:0] base_r [W];
  logic [NUM_LANES-1:0]        neg_r  [W];
  logic [NUM_LANES-1:0][W-1:0] d_r    [W];
  logic [NUM_LANES-1:0][W-1:0] rem_r  [W];
  // low dividend bits shift out while quotient bits shift in
  logic [NUM_LANES-1:0][W-1:0] rest_r [W];
  wire  [W:0]                  rdy;

  assign rdy[W]   = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic                        pv;
    tss_flags_t                  pflags;
    logic [W-1:0]                py;
    logic [NUM_LANES-1:0][W-1:0] pbase;
    logic [NUM_LANES-1:0]        pneg;
    logic [NUM_LANES-1:0][W-1:0] pd;
    logic [NUM_LANES-1:0][W-1:0] prem;
    logic [NUM_LANES-1:0][W-1:0] prest;
    logic [NUM_LANES-1:0][W-1:0] rem_nxt;
    logic [NUM_LANES-1:0][W-1:0] rest_nxt;

    if (s == 0) begin : g_head
      always_comb begin
        pv     = in_valid;
        pflags = in_flags;
        py     = in_y;
        pbase  = in_base;
        pneg   = in_neg;
        pd     = in_d;
        for (int l = 0; l < NUM_LANES; l++) begin
          // upper half is below the divisor since the quotient fits in W bits
          prem[l]  = in_m[l][2*W-1:W];
          prest[l] = in_m[l][W-1:0];
        end
      end
    end else begin : g_body
      always_comb begin
        pv     = v_r[s-1];
        pflags = flags_r[s-1];
        py     = y_r[s-1];
        pbase  = base_r[s-1];
        pneg   = neg_r[s-1];
        pd     = d_r[s-1];
        prem   = rem_r[s-1];
        prest  = rest_r[s-1];
      end
    end

    always_comb begin
      logic [W:0] trial;
      logic [W:0] diff;
      logic       ge;
      for (int l = 0; l < NUM_LANES; l++) begin
        trial       = {prem[l], prest[l][W-1]};
        diff        = trial - {1'b0, pd[l]};
        ge          = (trial >= {1'b0, pd[l]});
        rem_nxt[l]  = ge ? diff[W-1:0] : trial[W-1:0];
        rest_nxt[l] = {prest[l][W-2:0], ge};
      end
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        flags_r[s] <= pflags;
        y_r[s]     <= py;
        base_r[s]  <= pbase;
        neg_r[s]   <= pneg;
        d_r[s]     <= pd;
        rem_r[s]   <= rem_nxt;
        rest_r[s]  <= rest_nxt;
      end
    end
  end

  assign out_valid = v_r[W-1];
  assign out_flags = flags_r[W-1];
  assign out_y     = y_r[W-1];
  assign out_base  = base_r[W-1];
  assign out_neg   = neg_r[W-1];
  assign out_d     = d_r[W-1];
  assign out_rem   = rem_r[W-1];
  assign out_quo   = rest_r[W-1];

endmodule : tss_div

`default_nettype wire

/* design/tss_final.sv */
// output stage: round to nearest even, add to edge start, order left/right
// depends on tss_pkg
`default_nettype none

module tss_final
  import tss_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tss_flags_t                  in_flags,
  input  logic [W-1:0]                in_y,
  input  logic [NUM_LANES-1:0][W-1:0] in_base,
  input  logic [NUM_LANES-1:0]        in_neg,
  input  logic [NUM_LANES-1:0][W-1:0] in_d,
  input  logic [NUM_LANES-1:0][W-1:0] in_rem,
  input  logic [NUM_LANES-1:0][W-1:0] in_quo,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_span_valid,
  output logic [W-1:0]                out_span_y,
  output logic [W-1:0]                out_span_left,
  output logic [W-1:0]                out_span_right,
  output logic                        out_span_last
);

  logic                        v_r;
  logic                        span_valid_r;
  logic [W-1:0]                span_y_r;
  logic [W-1:0]                span_left_r;
  logic [W-1:0]                span_right_r;
  logic                        span_last_r;
  logic                        rdy;

  logic [NUM_LANES-1:0][W+1:0] pos_c;
  logic [W-1:0]                left_nxt;
  logic [W-1:0]                right_nxt;

  always_comb begin
    logic [W:0] twice_r;
    logic       up;
    logic [W:0] qr;
    for (int l = 0; l < NUM_LANES; l++) begin
      twice_r  = {in_rem[l], 1'b0};
      // round half to even
      up       = (twice_r > {1'b0, in_d[l]}) ||
                 ((twice_r == {1'b0, in_d[l]}) && in_quo[l][0]);
      qr       = {1'b0, in_quo[l]} + {{W{1'b0}}, up};
      pos_c[l] = in_neg[l] ? ({2'b00, in_base[l]} - {1'b0, qr})
                           : ({2'b00, in_base[l]} + {1'b0, qr});
    end
    if ($signed(pos_c[LANE_LONG]) > $signed(pos_c[LANE_SHORT])) begin
      left_nxt  = pos_c[LANE_SHORT][W-1:0];
      right_nxt = pos_c[LANE_LONG][W-1:0];
    end else begin
      left_nxt  = pos_c[LANE_LONG][W-1:0];
      right_nxt = pos_c[LANE_SHORT][W-1:0];
    end
  end

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      span_valid_r <= in_flags.span_valid;
      if (in_flags.span_valid) begin
        span_y_r     <= in_y;
        span_left_r  <= left_nxt;
        span_right_r <= right_nxt;
        span_last_r  <= in_flags.last;
      end else begin
        span_y_r     <= '0;
        span_left_r  <= '0;
        span_right_r <= '0;
        span_last_r  <= 1'b0;
      end
    end
  end

  assign out_valid      = v_r;
  assign out_span_valid = span_valid_r;
  assign out_span_y     = span_y_r;
  assign out_span_left  = span_left_r;
  assign out_span_right = span_right_r;
  assign out_span_last  = span_last_r;

endmodule : tss_final

`default_nettype wire

/* design/triangle_scanline_span_core.sv */
// Triangle scanline span core.
// in_ch takes one word per row query: three vertices and a row offset counted
// up from the lowest vertex y. out_ch returns one word per query: span_valid,
// the absolute row y, the inclusive left and right x, and span_last on the
// final covered row. Rows at or past the triangle height come back with
// span_valid low and all other fields zero; a triangle with all y equal
// covers only offset 0, from its smallest to its largest x.
// The pipe has COORD_BITS + 4 register stages (16 at the default width): sort,
// edge setup, multiply, one stage per quotient bit of the restoring divider,
// then round and order. A new word is taken every cycle while in_ch.ready is
// high. Each stage moves on when its successor can take its word, so bubbles
// fill in while out_ch is stalled and in_ch.ready drops only once the pipe
// holds a word in every stage. Results are never dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipe; there is no other state.
// Depends on tss_pkg, tss_in_if, tss_out_if and the tss_* stage modules.
`default_nettype none

module triangle_scanline_span_core
  import tss_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tss_in_if.sink    in_ch,
  tss_out_if.source out_ch
);

  localparam int unsigned W = COORD_BITS;

  logic                          su_valid;
  logic                          su_ready;
  tss_flags_t                    su_flags;
  logic [W-1:0]                  su_y;
  logic [NUM_LANES-1:0][W-1:0]   su_base;
  logic [NUM_LANES-1:0]          su_neg;
  logic [NUM_LANES-1:0][W-1:0]   su_mag;
  logic [NUM_LANES-1:0][W-1:0]   su_k;
  logic [NUM_LANES-1:0][W-1:0]   su_d;

  logic                          mu_valid;
  logic                          mu_ready;
  tss_flags_t                    mu_flags;
  logic [W-1:0]                  mu_y;
  logic [NUM_LANES-1:0][W-1:0]   mu_base;
  logic [NUM_LANES-1:0]          mu_neg;
  logic [NUM_LANES-1:0][W-1:0]   mu_d;
  logic [NUM_LANES-1:0][2*W-1:0] mu_m;

  logic                          dv_valid;
  logic                          dv_ready;
  tss_flags_t                    dv_flags;
  logic [W-1:0]                  dv_y;
  logic [NUM_LANES-1:0][W-1:0]   dv_base;
  logic [NUM_LANES-1:0]          dv_neg;
  logic [NUM_LANES-1:0][W-1:0]   dv_d;
  logic [NUM_LANES-1:0][W-1:0]   dv_rem;
  logic [NUM_LANES-1:0][W-1:0]   dv_quo;

  tss_setup #(.W(W)) u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .x0        (in_ch.first_x),
    .y0        (in_ch.first_y),
    .x1        (in_ch.second_x),
    .y1        (in_ch.second_y),
    .x2        (in_ch.third_x),
    .y2        (in_ch.third_y),
    .off       (in_ch.row_offset),
    .out_valid (su_valid),
    .out_ready (su_ready),
    .out_flags (su_flags),
    .out_y     (su_y),
    .out_base  (su_base),
    .out_neg   (su_neg),
    .out_mag   (su_mag),
    .out_k     (su_k),
    .out_d     (su_d)
  );

  tss_mul #(.W(W)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (su_valid),
    .in_ready  (su_ready),
    .in_flags  (su_flags),
    .in_y      (su_y),
    .in_base   (su_base),
    .in_neg    (su_neg),
    .in_mag    (su_mag),
    .in_k      (su_k),
    .in_d      (su_d),
    .out_valid (mu_valid),
    .out_ready (mu_ready),
    .out_flags (mu_flags),
    .out_y     (mu_y),
    .out_base  (mu_base),
    .out_neg   (mu_neg),
    .out_d     (mu_d),
    .out_m     (mu_m)
  );

  tss_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mu_valid),
    .in_ready  (mu_ready),
    .in_flags  (mu_flags),
    .in_y      (mu_y),
    .in_base   (mu_base),
    .in_neg    (mu_neg),
    .in_d      (mu_d),
    .in_m      (mu_m),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_flags (dv_flags),
    .out_y     (dv_y),
    .out_base  (dv_base),
    .out_neg   (dv_neg),
    .out_d     (dv_d),
    .out_rem   (dv_rem),
    .out_quo   (dv_quo)
  );

  tss_final #(.W(W)) u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (dv_valid),
    .in_ready       (dv_ready),
    .in_flags       (dv_flags),
    .in_y           (dv_y),
    .in_base        (dv_base),
    .in_neg         (dv_neg),
    .in_d           (dv_d),
    .in_rem         (dv_rem),
    .in_quo         (dv_quo),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_span_valid (out_ch.span_valid),
    .out_span_y     (out_ch.span_y),
    .out_span_left  (out_ch.span_left),
    .out_span_right (out_ch.span_right),
    .out_span_last  (out_ch.span_last)
  );

endmodule : triangle_scanline_span_core

`default_nettype wire

/* design/tss_checker.sv */
// port-level assertions for the triangle scanline span core, bound to the top
// depends on tss_pkg and triangle_scanline_span_core
`default_nettype none

module tss_checker
  import tss_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic         out_span_valid,
  input logic [W-1:0] out_span_y,
  input logic [W-1:0] out_span_left,
  input logic [W-1:0] out_span_right,
  input logic         out_span_last
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_span_valid, out_span_y, out_span_left, out_span_right, out_span_last}))
    else $error("result word changed while stalled");

  // with the receiver ready every stage can move, so input is taken
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output was ready");

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_valid |-> out_span_left <= out_span_right)
    else $error("span left beyond right");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_valid |->
      (out_span_y == '0) && (out_span_left == '0) && (out_span_right == '0) && !out_span_last)
    else $error("uncovered row carries nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule : tss_checker

bind triangle_scanline_span_core tss_checker #(.W(COORD_BITS)) u_tss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_span_valid (out_ch.span_valid),
  .out_span_y     (out_ch.span_y),
  .out_span_left  (out_ch.span_left),
  .out_span_right (out_ch.span_right),
  .out_span_last  (out_ch.span_last)
);

`default_nettype wire
